// ----- hdl/fpq_pkg.sv -----
`default_nettype none

package fpq_pkg;

    // Default sizes of the queue set.
    localparam int CLASS_COUNT_DEF = 5;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_BITS_DEF     = 16;

    // Fixed field widths.
    localparam int REQ_W       = 2;
    localparam int LEVEL_W     = 3;
    localparam int STIME_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int CLASS_OUT_W = 3;
    localparam int TOTAL_W     = 9;
    localparam int STAT_W      = 32;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_SERVE   = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_CLEAR   = 2'd3
    } fpq_req_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } fpq_status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_RESP = 2'd2
    } fpq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } fpq_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/fpq_ctrl.sv -----
`default_nettype none

module fpq_ctrl
    import fpq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output logic          done,
    output fpq_cmd_t      cmd
);

    fpq_state_t state_reg;
    fpq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A new request may be taken while the result is shown.
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                done = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The execute cycle always hands over to the result cycle.
    a_exec_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (done && !busy))
        else $error("execute cycle not followed by result cycle");

endmodule

`default_nettype wire

// ----- hdl/fpq_datapath.sv -----
`default_nettype none

module fpq_datapath
    import fpq_pkg::*;
#(
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fpq_cmd_t               cmd,
    input  wire logic [REQ_W-1:0]       req_type,
    input  wire logic [ID_BITS-1:0]     entry_id,
    input  wire logic [LEVEL_W-1:0]     level,
    input  wire logic [STIME_W-1:0]     service_time,
    output logic [STATUS_W-1:0]         status,
    output logic                        found,
    output logic [ID_BITS-1:0]          head_id,
    output logic [CLASS_OUT_W-1:0]      head_class,
    output logic [TOTAL_W-1:0]          total_waiting,
    output logic [STAT_W-1:0]           class_served_count,
    output logic [STAT_W-1:0]           class_time_sum
);

    localparam int CLS_W     = $clog2(CLASS_COUNT);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = CLASS_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int TOT_W     = $clog2(MEM_DEPTH + 1);

    // Captured request.
    fpq_req_t               req_type_reg;
    logic [ID_BITS-1:0]     entry_id_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [STIME_W-1:0]     stime_reg;

    // Queue bookkeeping and statistics.
    logic [PTR_W-1:0]       head_ptr_reg  [CLASS_COUNT];
    logic [PTR_W-1:0]       head_ptr_next [CLASS_COUNT];
    logic [PTR_W-1:0]       tail_ptr_reg  [CLASS_COUNT];
    logic [PTR_W-1:0]       tail_ptr_next [CLASS_COUNT];
    logic [OCC_W-1:0]       occ_reg       [CLASS_COUNT];
    logic [OCC_W-1:0]       occ_next      [CLASS_COUNT];
    logic [STAT_W-1:0]      count_reg     [CLASS_COUNT];
    logic [STAT_W-1:0]      count_next    [CLASS_COUNT];
    logic [STAT_W-1:0]      tsum_reg      [CLASS_COUNT];
    logic [STAT_W-1:0]      tsum_next     [CLASS_COUNT];
    logic [TOT_W-1:0]       total_reg;
    logic [TOT_W-1:0]       total_next;

    // Result registers.
    fpq_status_t            status_reg;
    fpq_status_t            status_next;
    logic                   found_reg;
    logic                   found_next;
    logic [CLS_W-1:0]       class_reg;
    logic [CLS_W-1:0]       class_next;
    logic [STAT_W-1:0]      cnt_out_reg;
    logic [STAT_W-1:0]      cnt_out_next;
    logic [STAT_W-1:0]      tsum_out_reg;
    logic [STAT_W-1:0]      tsum_out_next;

    // Entry storage.
    logic [ID_BITS-1:0]     entry_mem [MEM_DEPTH];
    logic [ID_BITS-1:0]     rd_data_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;

    // Class selection.
    logic [CLASS_COUNT-1:0] nonempty;
    logic                   any_waiting;
    logic [CLS_W-1:0]       hi_cls;
    logic [CLS_W-1:0]       lo_cls;
    logic [LEVEL_W-1:0]     lvl_m1;
    logic [CLS_W-1:0]       enq_cls;
    logic [CLS_W-1:0]       peek_cls;
    logic [CLS_W-1:0]       sel_cls;
    logic [PTR_W-1:0]       sel_ptr;
    logic [OCC_W-1:0]       sel_occ;
    logic [STAT_W-1:0]      cnt_sat;
    logic [STAT_W:0]        tsum_wide;
    logic [STAT_W-1:0]      tsum_sat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    // Capture the request at the transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= fpq_req_t'(req_type);
            entry_id_reg <= entry_id;
            level_reg    <= level;
            stime_reg    <= service_time;
        end
    end

    // Highest and lowest nonempty classes.
    always_comb
    begin
        hi_cls = '0;
        lo_cls = '0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            nonempty[c] = (occ_reg[c] != '0);
        end
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (nonempty[c])
            begin
                hi_cls = CLS_W'(c);
            end
        end
        for (int c = CLASS_COUNT - 1; c >= 0; c--)
        begin
            if (nonempty[c])
            begin
                lo_cls = CLS_W'(c);
            end
        end
        any_waiting = |nonempty;
    end

    // Enqueue clamps level-1; an out-of-range peek uses the lowest nonempty class.
    always_comb
    begin
        lvl_m1 = level_reg - LEVEL_W'(1);
        if (level_reg == '0)
        begin
            enq_cls = '0;
        end
        else if (32'(lvl_m1) > 32'(CLASS_COUNT - 1))
        begin
            enq_cls = CLS_W'(CLASS_COUNT - 1);
        end
        else
        begin
            enq_cls = CLS_W'(lvl_m1);
        end

        if (32'(level_reg) >= 32'(CLASS_COUNT))
        begin
            peek_cls = lo_cls;
        end
        else
        begin
            peek_cls = CLS_W'(level_reg);
        end
    end

    // Target class, its pointer and the storage address.
    always_comb
    begin
        case (req_type_reg)
            REQ_ENQUEUE: sel_cls = enq_cls;
            REQ_SERVE:   sel_cls = hi_cls;
            default:     sel_cls = peek_cls;
        endcase
        if (req_type_reg == REQ_ENQUEUE)
        begin
            sel_ptr = tail_ptr_reg[sel_cls];
        end
        else
        begin
            sel_ptr = head_ptr_reg[sel_cls];
        end
        sel_occ  = occ_reg[sel_cls];
        mem_addr = ADDR_W'(sel_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_ptr);
    end

    // Saturating statistics of the served class.
    always_comb
    begin
        if (count_reg[hi_cls] == '1)
        begin
            cnt_sat = count_reg[hi_cls];
        end
        else
        begin
            cnt_sat = count_reg[hi_cls] + STAT_W'(1);
        end
        tsum_wide = {1'b0, tsum_reg[hi_cls]} + (STAT_W + 1)'(stime_reg);
        tsum_sat  = tsum_wide[STAT_W] ? '1 : tsum_wide[STAT_W-1:0];
    end

    // Request execution.
    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        occ_next      = occ_reg;
        count_next    = count_reg;
        tsum_next     = tsum_reg;
        total_next    = total_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        class_next    = class_reg;
        cnt_out_next  = cnt_out_reg;
        tsum_out_next = tsum_out_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        if (cmd.exec)
        begin
            status_next   = STAT_OK;
            found_next    = 1'b0;
            class_next    = '0;
            cnt_out_next  = '0;
            tsum_out_next = '0;
            case (req_type_reg)
                REQ_ENQUEUE:
                begin
                    class_next = enq_cls;
                    if (sel_occ == OCC_W'(QUEUE_DEPTH))
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we                 = 1'b1;
                        tail_ptr_next[enq_cls] = ptr_inc(sel_ptr);
                        occ_next[enq_cls]      = sel_occ + OCC_W'(1);
                        total_next             = total_reg + TOT_W'(1);
                    end
                end
                REQ_SERVE:
                begin
                    if (!any_waiting)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        mem_re                = 1'b1;
                        head_ptr_next[hi_cls] = ptr_inc(sel_ptr);
                        occ_next[hi_cls]      = sel_occ - OCC_W'(1);
                        total_next            = total_reg - TOT_W'(1);
                        count_next[hi_cls]    = cnt_sat;
                        tsum_next[hi_cls]     = tsum_sat;
                        found_next            = 1'b1;
                        class_next            = hi_cls;
                        cnt_out_next          = cnt_sat;
                        tsum_out_next         = tsum_sat;
                    end
                end
                REQ_PEEK:
                begin
                    if (!any_waiting)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        class_next = peek_cls;
                        if (sel_occ != '0)
                        begin
                            mem_re     = 1'b1;
                            found_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    for (int c = 0; c < CLASS_COUNT; c++)
                    begin
                        head_ptr_next[c] = '0;
                        tail_ptr_next[c] = '0;
                        occ_next[c]      = '0;
                    end
                    total_next = '0;
                end
            endcase
        end
    end

    // Bookkeeping and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                head_ptr_reg[c] <= '0;
                tail_ptr_reg[c] <= '0;
                occ_reg[c]      <= '0;
                count_reg[c]    <= '0;
                tsum_reg[c]     <= '0;
            end
            total_reg    <= '0;
            status_reg   <= STAT_OK;
            found_reg    <= 1'b0;
            class_reg    <= '0;
            cnt_out_reg  <= '0;
            tsum_out_reg <= '0;
        end
        else
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            occ_reg      <= occ_next;
            count_reg    <= count_next;
            tsum_reg     <= tsum_next;
            total_reg    <= total_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
            class_reg    <= class_next;
            cnt_out_reg  <= cnt_out_next;
            tsum_out_reg <= tsum_out_next;
        end
    end

    // Entry storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_addr] <= entry_id_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[mem_addr];
        end
    end

    // Result ports.
    assign status             = status_reg;
    assign found              = found_reg;
    assign head_id            = found_reg ? rd_data_reg : '0;
    assign head_class         = CLASS_OUT_W'(class_reg);
    assign total_waiting      = TOTAL_W'(total_reg);
    assign class_served_count = cnt_out_reg;
    assign class_time_sum     = tsum_out_reg;

    // A reported head always comes with an ok status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (status_reg == STAT_OK))
        else $error("head reported with a failing status");

    // A clear leaves nothing waiting.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (req_type_reg == REQ_CLEAR)) |=> (total_reg == '0))
        else $error("entries left after clear");

    // No class holds more than its depth.
    generate
        for (genvar g = 0; g < CLASS_COUNT; g++)
        begin : g_occ_chk
            a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
                occ_reg[g] <= OCC_W'(QUEUE_DEPTH))
                else $error("class occupancy above depth");
        end
    endgenerate

endmodule

`default_nettype wire

// ----- hdl/five_level_priority_queue.sv -----
// Strict-priority queue set: CLASS_COUNT FIFO queues of entry identifiers.
// Requests come on the command channel: a request transfers at a rising edge
// where start is high and busy is low; req_type selects enqueue, serve, peek
// or clear, with entry_id, level and service_time as operands.
// Each request yields exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle.
// After the transfer comes the execute step, which issues at most one read or
// write of the entry memory and updates pointers, counts and statistics; the
// result step after it shows the registered read data. busy is low in the
// result cycle, so the next request can transfer there.
// Reset empties every queue and zeroes the per-class served counts and time
// sums. The entry memory itself is not cleared; it is only read at occupied
// slots.
`default_nettype none

module five_level_priority_queue
    import fpq_pkg::*;
#(
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [REQ_W-1:0]       req_type,
    input  wire logic [ID_BITS-1:0]     entry_id,
    input  wire logic [LEVEL_W-1:0]     level,
    input  wire logic [STIME_W-1:0]     service_time,
    output logic                        done,
    output logic [STATUS_W-1:0]         status,
    output logic                        found,
    output logic [ID_BITS-1:0]          head_id,
    output logic [CLASS_OUT_W-1:0]      head_class,
    output logic [TOTAL_W-1:0]          total_waiting,
    output logic [STAT_W-1:0]           class_served_count,
    output logic [STAT_W-1:0]           class_time_sum
);

    fpq_cmd_t cmd;

    // Request sequencing.
    fpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Queues, statistics and result registers.
    fpq_datapath #(
        .CLASS_COUNT (CLASS_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .req_type           (req_type),
        .entry_id           (entry_id),
        .level              (level),
        .service_time       (service_time),
        .status             (status),
        .found              (found),
        .head_id            (head_id),
        .head_class         (head_class),
        .total_waiting      (total_waiting),
        .class_served_count (class_served_count),
        .class_time_sum     (class_time_sum)
    );

    // A result only follows a cycle of execution.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding execute cycle");

endmodule

`default_nettype wire

// ----- dv/tb_five_level_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_five_level_priority_queue;
    import fpq_pkg::*;

    localparam int NUM_CLASSES  = CLASS_COUNT_DEF;
    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int IDW          = ID_BITS_DEF;
    localparam int RANDOM_ITEMS = 1350;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        fpq_req_t               kind;
        logic [IDW-1:0]         id;
        logic [LEVEL_W-1:0]     level;
        logic [STIME_W-1:0]     stime;
    } request_t;

    typedef struct packed {
        fpq_status_t            status;
        logic                   found;
        logic [IDW-1:0]         head_id;
        logic [CLASS_OUT_W-1:0] head_class;
        logic [TOTAL_W-1:0]     total;
        logic [STAT_W-1:0]      count;
        logic [STAT_W-1:0]      time_sum;
    } outcome_t;

    // Clock, reset and block inputs, all known from time zero.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [REQ_W-1:0]       req_type = '0;
    logic [IDW-1:0]         entry_id = '0;
    logic [LEVEL_W-1:0]     level = '0;
    logic [STIME_W-1:0]     service_time = '0;

    logic                   busy;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [IDW-1:0]         head_id;
    logic [CLASS_OUT_W-1:0] head_class;
    logic [TOTAL_W-1:0]     total_waiting;
    logic [STAT_W-1:0]      class_served_count;
    logic [STAT_W-1:0]      class_time_sum;

    // Shadow copy of the queue set.
    logic [IDW-1:0]         id_store [NUM_CLASSES][DEPTH];
    int unsigned            head_ptr [NUM_CLASSES];
    int unsigned            tail_ptr [NUM_CLASSES];
    int unsigned            fill [NUM_CLASSES];
    logic [STAT_W-1:0]      served_num [NUM_CLASSES];
    logic [STAT_W-1:0]      served_time [NUM_CLASSES];

    request_t               request_backlog [$];
    outcome_t               awaited_outcomes [$];
    request_t               cur_req;
    int                     gap_left = 0;
    int                     calm_left = 0;
    int                     error_count = 0;

    five_level_priority_queue u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .req_type           (req_type),
        .entry_id           (entry_id),
        .level              (level),
        .service_time       (service_time),
        .done               (done),
        .status             (status),
        .found              (found),
        .head_id            (head_id),
        .head_class         (head_class),
        .total_waiting      (total_waiting),
        .class_served_count (class_served_count),
        .class_time_sum     (class_time_sum)
    );

    always #5 clk = ~clk;

    // Saturating 32-bit addition used by the service statistics.
    function automatic logic [STAT_W-1:0] sat_sum(input logic [STAT_W-1:0] a,
                                                   input logic [STAT_W-1:0] b);
        logic [STAT_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[STAT_W] ? '1 : wide[STAT_W-1:0];
    endfunction

    // Apply one transferred request to the shadow queues and record its outcome.
    task automatic apply_request(input request_t r);
        outcome_t    o;
        int          sel;
        int          c;
        int unsigned cls;
        int unsigned total;
        o = '0;
        o.status = STAT_OK;
        case (r.kind)
            REQ_ENQUEUE:
            begin
                cls = (r.level == 0) ? 0 : int'(r.level) - 1;
                if (cls > NUM_CLASSES - 1)
                    cls = NUM_CLASSES - 1;
                o.head_class = CLASS_OUT_W'(cls);
                if (fill[cls] >= DEPTH)
                    o.status = STAT_FULL;
                else
                begin
                    id_store[cls][tail_ptr[cls]] = r.id;
                    tail_ptr[cls] = (tail_ptr[cls] + 1) % DEPTH;
                    fill[cls]++;
                end
            end
            REQ_SERVE:
            begin
                sel = -1;
                for (c = NUM_CLASSES - 1; c >= 0; c--)
                    if (sel < 0 && fill[c] != 0)
                        sel = c;
                if (sel < 0)
                    o.status = STAT_EMPTY;
                else
                begin
                    o.head_id = id_store[sel][head_ptr[sel]];
                    head_ptr[sel] = (head_ptr[sel] + 1) % DEPTH;
                    fill[sel]--;
                    served_num[sel] = sat_sum(served_num[sel], 1);
                    served_time[sel] = sat_sum(served_time[sel], STAT_W'(r.stime));
                    o.found = 1'b1;
                    o.head_class = CLASS_OUT_W'(sel);
                    o.count = served_num[sel];
                    o.time_sum = served_time[sel];
                end
            end
            REQ_PEEK:
            begin
                total = 0;
                for (c = 0; c < NUM_CLASSES; c++)
                    total += fill[c];
                if (total == 0)
                    o.status = STAT_EMPTY;
                else
                begin
                    cls = r.level;
                    // An out-of-range index picks the lowest class that holds entries.
                    if (cls >= NUM_CLASSES)
                    begin
                        sel = -1;
                        for (c = 0; c < NUM_CLASSES; c++)
                            if (sel < 0 && fill[c] != 0)
                                sel = c;
                        cls = sel;
                    end
                    o.head_class = CLASS_OUT_W'(cls);
                    if (fill[cls] != 0)
                    begin
                        o.found = 1'b1;
                        o.head_id = id_store[cls][head_ptr[cls]];
                    end
                end
            end
            default:
            begin
                for (c = 0; c < NUM_CLASSES; c++)
                begin
                    head_ptr[c] = 0;
                    tail_ptr[c] = 0;
                    fill[c] = 0;
                end
            end
        endcase
        total = 0;
        for (c = 0; c < NUM_CLASSES; c++)
            total += fill[c];
        o.total = TOTAL_W'(total);
        awaited_outcomes.push_back(o);
    endtask

    task automatic queue_request(input fpq_req_t kind, input logic [IDW-1:0] id,
                                 input int lvl, input logic [STIME_W-1:0] stime);
        request_t r;
        r.kind = kind;
        r.id = id;
        r.level = LEVEL_W'(lvl);
        r.stime = stime;
        request_backlog.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Driver: present requests, hold each until it transfers, then at times idle a while.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_request(cur_req);
                if (calm_left > 0)
                begin
                    calm_left--;
                    gap_left = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    calm_left = $urandom_range(8, 40);
                    gap_left = 0;
                end
                else
                    gap_left = $urandom_range(0, 6);
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    cur_req = request_backlog.pop_front();
                    req_type <= cur_req.kind;
                    entry_id <= cur_req.id;
                    level <= cur_req.level;
                    service_time <= cur_req.stime;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every result strobe is compared with the oldest outcome waiting.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with no request outstanding", $time);
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                check_field("status", want.status, status);
                check_field("found", want.found, found);
                check_field("head_id", want.head_id, head_id);
                check_field("head_class", want.head_class, head_class);
                check_field("total_waiting", want.total, total_waiting);
                check_field("class_served_count", want.count, class_served_count);
                check_field("class_time_sum", want.time_sum, class_time_sum);
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int c;
        int n;
        int i;
        int lvl;
        int pick;
        int random_added;
        for (c = 0; c < NUM_CLASSES; c++)
        begin
            head_ptr[c] = 0;
            tail_ptr[c] = 0;
            fill[c] = 0;
            served_num[c] = '0;
            served_time[c] = '0;
        end

        // Directed: empty cases, clamping, auto and named peeks, drain and clear.
        queue_request(REQ_SERVE, 16'h0000, 0, 16'hFFFF);
        queue_request(REQ_PEEK, 16'h0000, 7, 16'h0000);
        queue_request(REQ_PEEK, 16'h0000, 0, 16'h0000);
        queue_request(REQ_ENQUEUE, 16'h0000, 0, 16'h0000);
        queue_request(REQ_ENQUEUE, 16'hFFFF, 7, 16'hFFFF);
        queue_request(REQ_ENQUEUE, 16'h1234, 6, 16'h0000);
        queue_request(REQ_ENQUEUE, 16'hA5A5, 3, 16'h0000);
        queue_request(REQ_PEEK, 16'h0000, 1, 16'h0000);
        queue_request(REQ_PEEK, 16'h0000, 5, 16'h0000);
        queue_request(REQ_PEEK, 16'hFFFF, 6, 16'hFFFF);
        queue_request(REQ_PEEK, 16'h0000, 4, 16'h0000);
        queue_request(REQ_SERVE, 16'h0000, 0, 16'hFFFF);
        queue_request(REQ_SERVE, 16'h0000, 0, 16'h0000);
        queue_request(REQ_SERVE, 16'h0000, 0, 16'h0001);
        queue_request(REQ_SERVE, 16'hFFFF, 7, 16'h8000);
        queue_request(REQ_SERVE, 16'h0000, 0, 16'h0000);
        queue_request(REQ_ENQUEUE, 16'h5A5A, 1, 16'h0000);
        queue_request(REQ_ENQUEUE, 16'h0F0F, 2, 16'h0000);
        queue_request(REQ_CLEAR, 16'hFFFF, 7, 16'hFFFF);
        queue_request(REQ_PEEK, 16'h0000, 2, 16'h0000);
        queue_request(REQ_SERVE, 16'h0000, 0, 16'h0000);
        queue_request(REQ_ENQUEUE, 16'hC3C3, 4, 16'h0000);
        queue_request(REQ_PEEK, 16'h0000, 3, 16'h0000);

        // Random bursts: fill a class to its limit, drain, or mix all requests.
        random_added = 0;
        while (random_added < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                lvl = $urandom_range(0, 7);
                n = $urandom_range(50, 80);
                for (i = 0; i < n; i++)
                    if ($urandom_range(0, 9) == 0)
                        queue_request(REQ_PEEK, IDW'($urandom), $urandom_range(0, 7),
                                      STIME_W'($urandom));
                    else
                        queue_request(REQ_ENQUEUE, IDW'($urandom), lvl, STIME_W'($urandom));
            end
            else if (pick < 5)
            begin
                n = $urandom_range(20, 90);
                for (i = 0; i < n; i++)
                    if ($urandom_range(0, 7) == 0)
                        queue_request(REQ_PEEK, IDW'($urandom), $urandom_range(0, 7),
                                      STIME_W'($urandom));
                    else
                        queue_request(REQ_SERVE, IDW'($urandom), $urandom_range(0, 7),
                                      STIME_W'($urandom));
            end
            else
            begin
                n = $urandom_range(20, 60);
                for (i = 0; i < n; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                        queue_request(REQ_ENQUEUE, IDW'($urandom), $urandom_range(0, 7),
                                      STIME_W'($urandom));
                    else if (pick < 72)
                        queue_request(REQ_SERVE, IDW'($urandom), $urandom_range(0, 7),
                                      STIME_W'($urandom));
                    else if (pick < 97)
                        queue_request(REQ_PEEK, IDW'($urandom), $urandom_range(0, 7),
                                      STIME_W'($urandom));
                    else
                        queue_request(REQ_CLEAR, IDW'($urandom), $urandom_range(0, 7),
                                      STIME_W'($urandom));
                end
            end
            random_added += n;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every transfer and every result, then let the pipeline settle.
        while (request_backlog.size() != 0 || start || awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/fpq_pkg.sv
hdl/fpq_ctrl.sv
hdl/fpq_datapath.sv
hdl/five_level_priority_queue.sv
dv/tb_five_level_priority_queue.sv
